@@ src/udiv_pkg.sv @@
// Package: shared widths, control types and the sequencer state type of the divider.
`default_nettype none

package udiv_pkg;

  localparam int FIELD_WIDTH = 64;
  localparam int DATA_WIDTH_DEFAULT = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sub;
  } ctrl_t;

  typedef struct packed {
    logic rem;
    logic q;
    logic borrow;
  } link_t;

endpackage

`default_nettype wire

@@ src/udiv_in_if.sv @@
// Interface: operand word channel (dividend, divisor) with valid/ready.
`default_nettype none

interface udiv_in_if;
  import udiv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] dividend;
  logic [FIELD_WIDTH-1:0] divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink (input valid, dividend, divisor, output ready);
endinterface

`default_nettype wire

@@ src/udiv_out_if.sv @@
// Interface: result word channel (quotient, remainder, divide-by-zero flag) with valid/ready.
`default_nettype none

interface udiv_out_if;
  import udiv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] quotient;
  logic [FIELD_WIDTH-1:0] remainder;
  logic                   divide_by_zero;

  modport source (output valid, quotient, remainder, divide_by_zero, input ready);
  modport sink (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface

`default_nettype wire

@@ src/unsigned_divider_64.sv @@
// Top level: unsigned restoring divider built from a row of bit-slice cells.
// Path: an operand word loads the cells, the RUN state steps them, DONE fills the result register;
//   a zero divisor skips the steps.
// Throughput: one division at a time, one quotient bit per cycle through the cell row;
//   the borrow chain across all DATA_WIDTH cells sets the clock period.
// Reset: rst (synchronous) returns the sequencer to idle and empties the result register.
`default_nettype none

module unsigned_divider_64 #(
  parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  udiv_in_if.sink   operands,
  udiv_out_if.source results
);
  import udiv_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       count;
  logic                   dbz;
  ctrl_t                  ctrl;
  logic                   sub;
  logic                   out_load;
  logic                   out_valid;
  logic [FIELD_WIDTH-1:0] out_q;
  logic [FIELD_WIDTH-1:0] out_r;
  logic                   out_dbz;
  logic [DATA_WIDTH-1:0]  num_in;
  logic [DATA_WIDTH-1:0]  den_in;
  logic                   den_zero;
  link_t                  link [DATA_WIDTH];
  link_t                  link0;
  logic [DATA_WIDTH-1:0]  q_vec;
  logic [DATA_WIDTH-1:0]  rem_vec;

  assign num_in   = operands.dividend[DATA_WIDTH-1:0];
  assign den_in   = operands.divisor[DATA_WIDTH-1:0];
  assign den_zero = (den_in == '0);

  assign sub = link[DATA_WIDTH-1].rem | ~link[DATA_WIDTH-1].borrow;

  assign link0.rem    = link[DATA_WIDTH-1].q;
  assign link0.q      = sub;
  assign link0.borrow = 1'b0;

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    udiv_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_q   (num_in[i] & ~den_zero),
      .load_den (den_in[i]),
      .lo       ((i == 0) ? link0 : link[(i == 0) ? 0 : i - 1]),
      .hi       (link[i])
    );
    assign q_vec[i]   = link[i].q;
    assign rem_vec[i] = link[i].rem;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (operands.valid) state_next = den_zero ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (count == CNT_W'(DATA_WIDTH - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || results.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    operands.ready = 1'b0;
    ctrl.load      = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.sub       = sub;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        operands.ready = 1'b1;
        ctrl.load      = operands.valid;
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid || results.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        count <= '0;
      end else if (ctrl.step) begin
        count <= count + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dbz <= den_zero;
    end
    if (out_load) begin
      out_q   <= FIELD_WIDTH'(q_vec);
      out_r   <= FIELD_WIDTH'(rem_vec);
      out_dbz <= dbz;
    end
  end

  assign results.valid          = out_valid;
  assign results.quotient       = out_q;
  assign results.remainder      = out_r;
  assign results.divide_by_zero = out_dbz;

`ifndef SYNTH
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.divide_by_zero |->
      results.quotient == '0 && results.remainder == '0)
    else $error("divide-by-zero word carries nonzero quotient or remainder");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !operands.ready)
    else $error("operand word accepted while steps are in progress");

  a_zero_skip: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready && den_zero |=> state == ST_DONE)
    else $error("zero divisor did not skip the steps");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && !results.ready |=> state == ST_DONE)
    else $error("finished division dropped while result register is full");
`endif

endmodule

`default_nettype wire

@@ src/udiv_cell.sv @@
// Bit-slice cell: one bit of partial remainder, quotient/dividend and divisor.
`default_nettype none

module udiv_cell (
  input  wire logic            clk,
  input  wire udiv_pkg::ctrl_t ctrl,
  input  wire logic            load_q,
  input  wire logic            load_den,
  input  wire udiv_pkg::link_t lo,
  output udiv_pkg::link_t      hi
);
  import udiv_pkg::*;

  logic rem;
  logic q;
  logic den;
  logic diff;

  assign diff      = lo.rem ^ den ^ lo.borrow;
  assign hi.rem    = rem;
  assign hi.q      = q;
  assign hi.borrow = (~lo.rem & den) | (~(lo.rem ^ den) & lo.borrow);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= 1'b0;
      q   <= load_q;
      den <= load_den;
    end else if (ctrl.step) begin
      rem <= ctrl.sub ? diff : lo.rem;
      q   <= lo.q;
    end
  end

endmodule

`default_nettype wire

@@ verif/unsigned_divider_64_tb.sv @@
// Testbench: random and directed operand words through the divider, results checked in order.
`default_nettype none

module unsigned_divider_64_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udiv_pkg::*;

  localparam int DW           = DATA_WIDTH_DEFAULT;
  localparam int RANDOM_WORDS = 380;
  localparam int QUIET_WORDS  = 60;

  localparam logic [FIELD_WIDTH-1:0] OPERAND_MASK = {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - DW);

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] quotient;
    logic [FIELD_WIDTH-1:0] remainder;
    logic                   divide_by_zero;
  } div_result_t;

  class quotient_checker;
    div_result_t pending_results[$];
    int          mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function div_result_t divide_expected(logic [FIELD_WIDTH-1:0] dividend,
                                          logic [FIELD_WIDTH-1:0] divisor);
      div_result_t            res;
      logic [FIELD_WIDTH-1:0] num;
      logic [FIELD_WIDTH-1:0] den;
      num = dividend & OPERAND_MASK;
      den = divisor & OPERAND_MASK;
      res = '0;
      if (den == '0) begin
        res.divide_by_zero = 1'b1;
      end else begin
        res.quotient  = (num / den) & OPERAND_MASK;
        res.remainder = (num % den) & OPERAND_MASK;
      end
      return res;
    endfunction

    function void note_operands(logic [FIELD_WIDTH-1:0] dividend,
                                logic [FIELD_WIDTH-1:0] divisor);
      pending_results.push_back(divide_expected(dividend, divisor));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
    endtask

    task check_result(logic [FIELD_WIDTH-1:0] quotient, logic [FIELD_WIDTH-1:0] remainder,
                      logic divide_by_zero);
      div_result_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word q=%h r=%h dbz=%b",
                                  quotient, remainder, divide_by_zero));
        return;
      end
      exp = pending_results.pop_front();
      if (quotient !== exp.quotient)
        report_mismatch($sformatf("quotient %h, expected %h", quotient, exp.quotient));
      if (remainder !== exp.remainder)
        report_mismatch($sformatf("remainder %h, expected %h", remainder, exp.remainder));
      if (divide_by_zero !== exp.divide_by_zero)
        report_mismatch($sformatf("divide_by_zero %b, expected %b",
                                  divide_by_zero, exp.divide_by_zero));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   quiet = 1'b0;

  quotient_checker board = new();

  udiv_in_if  operands();
  udiv_out_if results();

  unsigned_divider_64 #(.DATA_WIDTH(DW)) DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .results  (results)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [FIELD_WIDTH-1:0] dividend,
                           input logic [FIELD_WIDTH-1:0] divisor);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      operands.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    operands.valid    <= 1'b1;
    operands.dividend <= dividend;
    operands.divisor  <= divisor;
    @(posedge clk);
    while (!operands.ready) @(posedge clk);
    board.note_operands(dividend, divisor);
  endtask

  function automatic logic [FIELD_WIDTH-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] shaped_word(logic [FIELD_WIDTH-1:0] near);
    logic [FIELD_WIDTH-1:0] w;
    w = random_word();
    case ($urandom_range(0, 7))
      0, 1, 2: w = w >> $urandom_range(0, FIELD_WIDTH - 1);
      3:       w = FIELD_WIDTH'($urandom_range(1, 255));
      4:       w = near - FIELD_WIDTH'($urandom_range(0, 3));
      5:       w = 64'd1 << $urandom_range(0, FIELD_WIDTH - 1);
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      board.check_result(results.quotient, results.remainder, results.divide_by_zero);
  end

  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      results.ready <= 1'b1;
    end
  end

  initial begin
    int                     n;
    logic [FIELD_WIDTH-1:0] a;
    logic [FIELD_WIDTH-1:0] b;

    rst               <= 1'b1;
    operands.valid    <= 1'b0;
    operands.dividend <= '0;
    operands.divisor  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(64'd0, 64'd0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_word(64'h1234_5678_9ABC_DEF0, 64'd0);
    send_word(64'd0, 64'd1);
    send_word(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'd1, 64'd1);
    send_word(64'd7, 64'd100);
    send_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd2);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
    send_word(64'h8000_0000_0000_0000, 64'd1);
    send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_word(64'hDEAD_BEEF_CAFE_F00D, 64'h0000_0001_0000_0000);
    send_word(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF);
    send_word(64'd100, 64'd7);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= RANDOM_WORDS - QUIET_WORDS);
      a = shaped_word(random_word());
      if ($urandom_range(0, 19) == 0)
        b = '0;
      else
        b = shaped_word(a);
      send_word(a, b);
    end
    operands.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DW + 8) @(posedge clk);

    if (board.mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
